/* rtl/core/bba_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared widths, codes, control word types and the sequencer program.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int CMD_W      = 2;
	localparam int ADDR_W     = 32;
	localparam int STATUS_W   = 3;
	localparam int FB_W       = 21;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int BSL_W      = 4;
	localparam int BIU_W      = 9;
	localparam int GUARD_W    = 4;

	localparam int ROW_W      = 32;
	localparam int BIT_W      = 5;
	localparam int STRIDE_W   = 13;
	localparam int LG_MAX     = 12;
	localparam int GUARD_MAX  = 8;

	localparam logic [FB_W-1:0] FB_MAX = '1;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	localparam logic [STATUS_W-1:0] ST_ALLOCATED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_BLOCK     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FREED        = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_INVALID      = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_LOG2 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GUARD_BYTES     = 2'd3;

	typedef logic [3:0] pc_t;

	localparam pc_t PC_CLEAR        = 4'd0;
	localparam pc_t PC_IDLE         = 4'd1;
	localparam pc_t PC_RESULT       = 4'd2;
	localparam pc_t PC_ALLOC        = 4'd3;
	localparam pc_t PC_ALLOC_SCAN   = 4'd4;
	localparam pc_t PC_ALLOC_MARK   = 4'd5;
	localparam pc_t PC_ALLOC_ADDR   = 4'd6;
	localparam pc_t PC_QUERY        = 4'd7;
	localparam pc_t PC_QUERY_COUNT  = 4'd8;
	localparam pc_t PC_QUERY_TOTAL  = 4'd9;
	localparam pc_t PC_FREE         = 4'd10;
	localparam pc_t PC_FREE_RANGE   = 4'd11;
	localparam pc_t PC_FREE_DIV     = 4'd12;
	localparam pc_t PC_FREE_ROW     = 4'd13;
	localparam pc_t PC_FREE_READ    = 4'd14;
	localparam pc_t PC_FREE_UPDATE  = 4'd15;

	typedef enum logic [3:0] {
		OP_CLEAR   = 4'd0,
		OP_ACCEPT  = 4'd1,
		OP_RESULT  = 4'd2,
		OP_READ    = 4'd3,
		OP_SCAN    = 4'd4,
		OP_MARK    = 4'd5,
		OP_ADDR    = 4'd6,
		OP_COUNT   = 4'd7,
		OP_FBYTES  = 4'd8,
		OP_OFFSET  = 4'd9,
		OP_DIVINIT = 4'd10,
		OP_DIVSTEP = 4'd11,
		OP_SETROW  = 4'd12,
		OP_FREE    = 4'd13
	} op_e;

	typedef enum logic [3:0] {
		J_NEXT     = 4'd0,
		J_ALWAYS   = 4'd1,
		J_DISPATCH = 4'd2,
		J_RESULT   = 4'd3,
		J_SCAN     = 4'd4,
		J_MORE     = 4'd5,
		J_RANGE    = 4'd6,
		J_DIV      = 4'd7,
		J_REM      = 4'd8,
		J_CLEAR    = 4'd9
	} jmp_e;

	typedef struct packed {
		op_e  op;
		jmp_e jmp;
		pc_t  target;
	} ctl_word_t;

	typedef struct packed {
		logic             in_valid;
		logic [CMD_W-1:0] cmd;
		logic             rsp_busy;
		logic             found;
		logic             more;
		logic             out_of_range;
		logic             rem_nz;
		logic             div_more;
		logic             clr_more;
	} seq_flags_t;

	function automatic ctl_word_t ucode(input pc_t pc);
		ctl_word_t w;
		case (pc)
			PC_CLEAR:       w = '{op: OP_CLEAR,   jmp: J_CLEAR,    target: PC_CLEAR};
			PC_IDLE:        w = '{op: OP_ACCEPT,  jmp: J_DISPATCH, target: PC_IDLE};
			PC_RESULT:      w = '{op: OP_RESULT,  jmp: J_RESULT,   target: PC_IDLE};
			PC_ALLOC:       w = '{op: OP_READ,    jmp: J_NEXT,     target: PC_IDLE};
			PC_ALLOC_SCAN:  w = '{op: OP_SCAN,    jmp: J_SCAN,     target: PC_ALLOC};
			PC_ALLOC_MARK:  w = '{op: OP_MARK,    jmp: J_NEXT,     target: PC_IDLE};
			PC_ALLOC_ADDR:  w = '{op: OP_ADDR,    jmp: J_ALWAYS,   target: PC_RESULT};
			PC_QUERY:       w = '{op: OP_READ,    jmp: J_NEXT,     target: PC_IDLE};
			PC_QUERY_COUNT: w = '{op: OP_COUNT,   jmp: J_MORE,     target: PC_QUERY};
			PC_QUERY_TOTAL: w = '{op: OP_FBYTES,  jmp: J_ALWAYS,   target: PC_RESULT};
			PC_FREE:        w = '{op: OP_OFFSET,  jmp: J_NEXT,     target: PC_IDLE};
			PC_FREE_RANGE:  w = '{op: OP_DIVINIT, jmp: J_RANGE,    target: PC_RESULT};
			PC_FREE_DIV:    w = '{op: OP_DIVSTEP, jmp: J_DIV,      target: PC_FREE_DIV};
			PC_FREE_ROW:    w = '{op: OP_SETROW,  jmp: J_REM,      target: PC_RESULT};
			PC_FREE_READ:   w = '{op: OP_READ,    jmp: J_NEXT,     target: PC_IDLE};
			PC_FREE_UPDATE: w = '{op: OP_FREE,    jmp: J_ALWAYS,   target: PC_RESULT};
			default:        w = '{op: OP_ACCEPT,  jmp: J_DISPATCH, target: PC_IDLE};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/bba_ifs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap block allocator channel interfaces
// Request, response and configuration write channels with valid and ready.
// ----------------------------------------------------------------------------
interface bba_req_if;
	import bba_pkg::*;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [ADDR_W-1:0] block_address;
	modport source (output valid, output command, output block_address, input ready);
	modport sink (input valid, input command, input block_address, output ready);
endinterface

interface bba_rsp_if;
	import bba_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   alloc_address;
	logic [FB_W-1:0]     free_bytes;
	modport source (output valid, output status, output alloc_address, output free_bytes,
		input ready);
	modport sink (input valid, input status, input alloc_address, input free_bytes,
		output ready);
endinterface

interface bba_cfg_if;
	import bba_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/bba_sequencer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap block allocator sequencer
// Step counter over the control program with conditional jumps and dispatch.
// ----------------------------------------------------------------------------
module bba_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  bba_pkg::seq_flags_t flags,
	output bba_pkg::op_e        op
);
	import bba_pkg::*;

	pc_t       pc_q;
	pc_t       pc_d;
	pc_t       pc_inc;
	pc_t       pc_disp;
	ctl_word_t ctl;

	always_comb begin
		ctl    = ucode(pc_q);
		op     = ctl.op;
		pc_inc = pc_q + pc_t'(1);
		case (flags.cmd)
			CMD_ALLOC: pc_disp = PC_ALLOC;
			CMD_FREE:  pc_disp = PC_FREE;
			CMD_QUERY: pc_disp = PC_QUERY;
			default:   pc_disp = PC_RESULT;
		endcase
		case (ctl.jmp)
			J_NEXT:     pc_d = pc_inc;
			J_ALWAYS:   pc_d = ctl.target;
			J_DISPATCH: pc_d = flags.in_valid ? pc_disp : pc_q;
			J_RESULT:   pc_d = flags.rsp_busy ? pc_q : ctl.target;
			J_SCAN:     pc_d = (!flags.found && flags.more) ? ctl.target : pc_inc;
			J_MORE:     pc_d = flags.more ? ctl.target : pc_inc;
			J_RANGE:    pc_d = flags.out_of_range ? ctl.target : pc_inc;
			J_DIV:      pc_d = flags.div_more ? ctl.target : pc_inc;
			J_REM:      pc_d = flags.rem_nz ? ctl.target : pc_inc;
			J_CLEAR:    pc_d = flags.clr_more ? ctl.target : pc_inc;
			default:    pc_d = PC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_CLEAR;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/bitmap_block_allocator.sv */
`default_nettype none
// One transaction at a time. Allocate scans the 32-bit map rows until one has a free block,
// query scans them all; the rows scanned are one with no managed block and else at most
// ceil(min(blocks_in_use, NUM_BLOCKS)/32). Free checks the heap range, finds the index with the
// bit-serial divider and rejects a misaligned address; an address past the heap ends before the
// divider, an unused command goes straight to the result, which is loaded as the sequencer
// returns to idle. Reset loads the register defaults, then clears all ceil(NUM_BLOCKS/32) rows.
// ----------------------------------------------------------------------------
// Bitmap block allocator
// Fixed-size block allocator with a used bit per block, run by a microcoded
// sequencer over a small shared datapath.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
	parameter int NUM_BLOCKS = 256,
	parameter int ADDR_BITS  = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	bba_req_if.sink      req,
	bba_rsp_if.source    rsp,
	bba_cfg_if.sink      cfg
);
	import bba_pkg::*;

	localparam int ROWS    = (NUM_BLOCKS + ROW_W - 1) / ROW_W;
	localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int FI_W    = ROW_AW + BIT_W;
	localparam int IDX_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
	localparam int MUL_A_W = (FI_W > CNT_W) ? FI_W : CNT_W;
	localparam int MUL_W   = MUL_A_W + STRIDE_W;
	localparam int REM_W   = IDX_W + STRIDE_W;
	localparam int CMP_W   = (ADDR_BITS > MUL_W) ? ADDR_BITS : MUL_W;
	localparam int KW      = (IDX_W > 1) ? $clog2(IDX_W) : 1;
	localparam int MW      = MUL_A_W + 1;
	localparam int FBX_W   = (CNT_W + LG_MAX > FB_W) ? CNT_W + LG_MAX : FB_W;

	logic [CFG_DATA_W-1:0] base_q;
	logic [BSL_W-1:0]      bsl_q;
	logic [BIU_W-1:0]      biu_q;
	logic [GUARD_W-1:0]    guard_q;

	logic [ADDR_W-1:0]     addr_q;
	logic [ROW_AW-1:0]     row_q;
	logic [BIT_W-1:0]      bit_q;
	logic                  hit_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [STATUS_W-1:0]   st_q;
	logic [ADDR_W-1:0]     aaddr_q;
	logic [FB_W-1:0]       fb_q;
	logic [ADDR_BITS-1:0]  off_q;
	logic [MUL_W-1:0]      prod_q;
	logic [REM_W-1:0]      rem_q;
	logic [REM_W-1:0]      dvs_q;
	logic [IDX_W-1:0]      quo_q;
	logic [KW-1:0]         k_q;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [ADDR_W-1:0]     out_addr_q;
	logic [FB_W-1:0]       out_fb_q;

	logic [ROW_W-1:0]      mem_q [ROWS];
	logic [ROW_W-1:0]      rd_q;

	op_e                   op;
	seq_flags_t            flags;
	logic [BSL_W-1:0]      lg;
	logic [GUARD_W-1:0]    guard_len;
	logic [STRIDE_W-1:0]   payload;
	logic [STRIDE_W-1:0]   stride;
	logic [CNT_W-1:0]      n;
	logic [ROW_AW-1:0]     last_row;
	logic                  more;
	logic [MW-1:0]         mask_n;
	logic [MW-1:0]         mask_base;
	logic [MW-1:0]         mask_diff;
	logic [ROW_W-1:0]      row_mask;
	logic [ROW_W-1:0]      free_bits;
	logic [ROW_W-1:0]      low_bit;
	logic                  found;
	logic [BIT_W-1:0]      enc;
	logic [BIT_W:0]        pop;
	logic [MUL_A_W-1:0]    mul_a;
	logic [MUL_W-1:0]      mul_p;
	logic                  div_ge;
	logic [FI_W-1:0]       idx_ext;
	logic [FBX_W-1:0]      fb_wide;
	logic [FB_W-1:0]       fb_sat;
	logic [ROW_W-1:0]      bit_sel;
	logic                  mem_we;
	logic [ROW_W-1:0]      mem_wdata;
	logic                  do_result;
	logic                  rsp_busy;

	function automatic logic [BIT_W:0] pop32(input logic [ROW_W-1:0] v);
		logic [3:0]     part [4];
		logic [BIT_W:0] s;
		for (int b = 0; b < 4; b++) begin
			part[b] = '0;
			for (int j = 0; j < 8; j++) begin
				part[b] = part[b] + {3'b000, v[b * 8 + j]};
			end
		end
		s = ({2'b00, part[0]} + {2'b00, part[1]}) + ({2'b00, part[2]} + {2'b00, part[3]});
		return s;
	endfunction

	bba_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.op     (op)
	);

	always_comb begin
		lg        = (bsl_q > BSL_W'(LG_MAX)) ? BSL_W'(LG_MAX) : bsl_q;
		guard_len = (guard_q > GUARD_W'(GUARD_MAX)) ? GUARD_W'(GUARD_MAX) : guard_q;
		payload   = STRIDE_W'(1) << lg;
		stride    = payload + STRIDE_W'({guard_len, 1'b0});
		n         = (int'(biu_q) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(biu_q);
		last_row  = (n == '0) ? '0 : ROW_AW'((n - CNT_W'(1)) >> BIT_W);
		more      = (row_q != last_row);

		mask_n    = MW'(n);
		mask_base = MW'({row_q, {BIT_W{1'b0}}});
		mask_diff = mask_n - mask_base;
		if (mask_n <= mask_base) begin
			row_mask = '0;
		end else if (mask_diff >= MW'(ROW_W)) begin
			row_mask = '1;
		end else begin
			row_mask = ~({ROW_W{1'b1}} << mask_diff[BIT_W-1:0]);
		end

		free_bits = ~rd_q & row_mask;
		found     = |free_bits;
		low_bit   = free_bits & (~free_bits + ROW_W'(1));
		enc       = '0;
		for (int j = 0; j < ROW_W; j++) begin
			if (low_bit[j]) begin
				enc = enc | BIT_W'(j);
			end
		end
		pop = pop32(free_bits);

		mul_a  = (op == OP_OFFSET) ? MUL_A_W'(n) : MUL_A_W'({row_q, bit_q});
		mul_p  = MUL_W'(mul_a) * MUL_W'(stride);
		div_ge = (rem_q >= dvs_q);
		idx_ext = FI_W'(quo_q);

		fb_wide = FBX_W'(cnt_q) << lg;
		fb_sat  = (fb_wide > FBX_W'(FB_MAX)) ? FB_MAX : FB_W'(fb_wide);

		bit_sel = ROW_W'(1) << bit_q;
		case (op)
			OP_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = '0;
			end
			OP_MARK: begin
				mem_we    = hit_q;
				mem_wdata = rd_q | bit_sel;
			end
			OP_FREE: begin
				mem_we    = rd_q[bit_q];
				mem_wdata = rd_q & ~bit_sel;
			end
			default: begin
				mem_we    = 1'b0;
				mem_wdata = rd_q;
			end
		endcase

		rsp_busy  = out_valid_q && !rsp.ready;
		do_result = (op == OP_RESULT) && !rsp_busy;

		flags.in_valid     = req.valid;
		flags.cmd          = req.command;
		flags.rsp_busy     = rsp_busy;
		flags.found        = found;
		flags.more         = more;
		flags.out_of_range = (CMP_W'(off_q) >= CMP_W'(prod_q));
		flags.rem_nz       = (rem_q != '0);
		flags.div_more     = (k_q != '0);
		flags.clr_more     = (row_q != ROW_AW'(ROWS - 1));
	end

	assign req.ready         = (op == OP_ACCEPT);
	assign cfg.ready         = 1'b1;
	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.alloc_address = out_addr_q;
	assign rsp.free_bytes    = out_fb_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[row_q] <= mem_wdata;
		end
		if (op == OP_READ) begin
			rd_q <= mem_q[row_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			bsl_q       <= BSL_W'(4);
			biu_q       <= BIU_W'(256);
			guard_q     <= GUARD_W'(8);
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_HEAP_BASE:       base_q  <= cfg.data;
					REG_BLOCK_SIZE_LOG2: bsl_q   <= cfg.data[BSL_W-1:0];
					REG_BLOCKS_IN_USE:   biu_q   <= cfg.data[BIU_W-1:0];
					REG_GUARD_BYTES:     guard_q <= cfg.data[GUARD_W-1:0];
					default: ;
				endcase
			end
			case (op)
				OP_CLEAR:  row_q <= row_q + ROW_AW'(1);
				OP_ACCEPT: if (req.valid) row_q <= '0;
				OP_SCAN:   if (!found && more) row_q <= row_q + ROW_AW'(1);
				OP_COUNT:  if (more) row_q <= row_q + ROW_AW'(1);
				OP_SETROW: row_q <= idx_ext[FI_W-1:BIT_W];
				default: ;
			endcase
			if (do_result) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_result) begin
			out_status_q <= st_q;
			out_addr_q   <= aaddr_q;
			out_fb_q     <= fb_q;
		end
		case (op)
			OP_ACCEPT: begin
				if (req.valid) begin
					addr_q  <= req.block_address;
					hit_q   <= 1'b0;
					cnt_q   <= '0;
					st_q    <= ST_INVALID;
					aaddr_q <= '0;
					fb_q    <= '0;
				end
			end
			OP_SCAN: begin
				if (found) begin
					hit_q <= 1'b1;
					bit_q <= enc;
				end
			end
			OP_MARK: begin
				prod_q <= mul_p;
				st_q   <= hit_q ? ST_ALLOCATED : ST_NO_BLOCK;
			end
			OP_ADDR: begin
				if (hit_q) begin
					aaddr_q <= ADDR_W'(ADDR_BITS'(base_q) + ADDR_BITS'(prod_q)
						+ ADDR_BITS'(guard_len));
				end
			end
			OP_COUNT: cnt_q <= cnt_q + CNT_W'(pop);
			OP_FBYTES: begin
				fb_q <= fb_sat;
				st_q <= ST_ALLOCATED;
			end
			OP_OFFSET: begin
				off_q  <= ADDR_BITS'(addr_q) - ADDR_BITS'(base_q) - ADDR_BITS'(guard_len);
				prod_q <= mul_p;
			end
			OP_DIVINIT: begin
				rem_q <= REM_W'(off_q);
				dvs_q <= REM_W'(stride) << (IDX_W - 1);
				quo_q <= '0;
				k_q   <= KW'(IDX_W - 1);
			end
			OP_DIVSTEP: begin
				if (div_ge) begin
					rem_q <= rem_q - dvs_q;
				end
				dvs_q <= dvs_q >> 1;
				quo_q <= IDX_W'({quo_q, div_ge});
				k_q   <= k_q - KW'(1);
			end
			OP_SETROW: bit_q <= idx_ext[BIT_W-1:0];
			OP_FREE:   st_q  <= rd_q[bit_q] ? ST_FREED : ST_ALREADY_FREE;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

/* verif/bitmap_block_allocator_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap block allocator checker
// Watches the request, response and configuration channels. It keeps its own
// copy of the registers and the used map, works out the response to each
// accepted request and compares every response with the oldest one awaited.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_checker #(
	parameter int NUM_BLOCKS = 256
) (
	input  logic clk,
	input  logic arst_n,
	bba_req_if   req,
	bba_rsp_if   rsp,
	bba_cfg_if   cfg,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import bba_pkg::*;

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   alloc_address;
		logic [FB_W-1:0]     free_bytes;
	} heap_reply_t;

	heap_reply_t         awaited_replies[$];
	heap_reply_t         want;
	heap_reply_t         got;
	logic [ADDR_W-1:0]   base_q;
	logic [BSL_W-1:0]    size_lg_q;
	logic [BIU_W-1:0]    count_q;
	logic [GUARD_W-1:0]  guard_q;
	logic                taken [NUM_BLOCKS];

	function automatic heap_reply_t serve_request(input logic [CMD_W-1:0] cmd,
		input logic [ADDR_W-1:0] addr);
		heap_reply_t r;
		logic [31:0] payload;
		logic [31:0] guard;
		logic [31:0] stride;
		logic [31:0] offset;
		logic [31:0] index;
		logic [31:0] total;
		int          n;
		int          free_count;
		int          i;
		r = '{status: ST_INVALID, alloc_address: '0, free_bytes: '0};
		payload = 32'd1 << ((size_lg_q > LG_MAX) ? LG_MAX : size_lg_q);
		guard = (guard_q > GUARD_MAX) ? GUARD_MAX : guard_q;
		stride = payload + 2 * guard;
		n = (count_q > NUM_BLOCKS) ? NUM_BLOCKS : count_q;
		case (cmd)
			CMD_ALLOC: begin
				r.status = ST_NO_BLOCK;
				for (i = 0; i < n; i++) begin
					if (!taken[i]) begin
						taken[i] = 1'b1;
						r.status = ST_ALLOCATED;
						r.alloc_address = base_q + i * stride + guard;
						break;
					end
				end
			end
			CMD_FREE: begin
				offset = addr - base_q - guard;
				if (offset % stride == 0) begin
					index = offset / stride;
					if (index < n) begin
						if (taken[index]) begin
							taken[index] = 1'b0;
							r.status = ST_FREED;
						end else begin
							r.status = ST_ALREADY_FREE;
						end
					end
				end
			end
			CMD_QUERY: begin
				free_count = 0;
				for (i = 0; i < n; i++) begin
					if (!taken[i])
						free_count++;
				end
				total = free_count * payload;
				r.free_bytes = (total > FB_MAX) ? FB_MAX : total[FB_W-1:0];
				r.status = ST_ALLOCATED;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q = '0;
			size_lg_q = 4'd4;
			count_q = 9'd256;
			guard_q = 4'd8;
			for (int i = 0; i < NUM_BLOCKS; i++)
				taken[i] = 1'b0;
			awaited_replies.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = '{status: rsp.status, alloc_address: rsp.alloc_address,
					free_bytes: rsp.free_bytes};
				if (awaited_replies.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("unexpected response transaction: %0d %h %0d",
							got.status, got.alloc_address, got.free_bytes);
				end else begin
					want = awaited_replies.pop_front();
					if (got.status !== want.status || got.alloc_address !== want.alloc_address
						|| got.free_bytes !== want.free_bytes) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("mismatch: expected %0d %h %0d, actual %0d %h %0d",
								want.status, want.alloc_address, want.free_bytes,
								got.status, got.alloc_address, got.free_bytes);
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_HEAP_BASE:       base_q = cfg.data[ADDR_W-1:0];
					REG_BLOCK_SIZE_LOG2: size_lg_q = cfg.data[BSL_W-1:0];
					REG_BLOCKS_IN_USE:   count_q = cfg.data[BIU_W-1:0];
					REG_GUARD_BYTES:     guard_q = cfg.data[GUARD_W-1:0];
					default: begin
					end
				endcase
			end
			if (req.valid && req.ready)
				awaited_replies.push_back(serve_request(req.command, req.block_address));
			pending = awaited_replies.size();
		end
	end

endmodule
`default_nettype wire

/* verif/bitmap_block_allocator_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Drives a directed sequence over the corner cases, then random phases of
// allocate, free and query transactions under many register settings, with
// random stalls on both channels. The checker beside the block predicts and
// compares every response; this module gives the verdict.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import bba_pkg::*;

	localparam int NUM_BLOCKS      = 256;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int SETTLE_CYCLES   = 4;
	localparam int RANDOM_PHASES   = 14;
	localparam int ITEMS_PER_PHASE = 120;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic steady;
	int   errors;
	int   pending;
	int unsigned cycle_count = 0;

	logic [ADDR_W-1:0]  cur_base;
	logic [BSL_W-1:0]   cur_lg;
	logic [BIU_W-1:0]   cur_n;
	logic [GUARD_W-1:0] cur_guard;

	bba_req_if req_ch ();
	bba_rsp_if rsp_ch ();
	bba_cfg_if cfg_ch ();

	bitmap_block_allocator #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.ADDR_BITS (32)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	bitmap_block_allocator_checker #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_check (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch),
		.errors (errors),
		.pending(pending)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL bitmap_block_allocator");
			$finish;
		end
	end

	always @(negedge clk)
		rsp_ch.ready = steady || ($urandom_range(99) >= 21);

	function automatic logic [31:0] guard_len();
		return (cur_guard > GUARD_MAX) ? GUARD_MAX : cur_guard;
	endfunction

	function automatic logic [31:0] block_stride();
		return (32'd1 << ((cur_lg > LG_MAX) ? LG_MAX : cur_lg)) + 2 * guard_len();
	endfunction

	function automatic int managed();
		return (cur_n > NUM_BLOCKS) ? NUM_BLOCKS : cur_n;
	endfunction

	function automatic logic [31:0] payload_start(input int k);
		return cur_base + k * block_stride() + guard_len();
	endfunction

	function automatic logic [31:0] random_free_address();
		int          n;
		int          roll;
		logic [31:0] stride;
		n = managed();
		stride = block_stride();
		roll = $urandom_range(99);
		if (roll < 35 && n > 0)
			return payload_start($urandom_range((n < 16) ? n - 1 : 15));
		else if (roll < 70 && n > 0)
			return payload_start($urandom_range(n - 1));
		else if (roll < 80)
			return payload_start(n + $urandom_range(2));
		else if (roll < 90 && stride > 1)
			return payload_start($urandom_range(n)) + $urandom_range(stride - 1, 1);
		else
			return $urandom();
	endfunction

	task automatic send(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
		while (!steady && $urandom_range(99) < 21) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.command = cmd;
		req_ch.block_address = addr;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	task automatic settle();
		req_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apply_setting(input logic [ADDR_W-1:0] base, input logic [BSL_W-1:0] lg,
		input logic [BIU_W-1:0] n, input logic [GUARD_W-1:0] guard);
		settle();
		write_reg(REG_HEAP_BASE, base);
		write_reg(REG_BLOCK_SIZE_LOG2, ($urandom() & ~32'hF) | lg);
		write_reg(REG_BLOCKS_IN_USE, ($urandom() & ~32'h1FF) | n);
		write_reg(REG_GUARD_BYTES, ($urandom() & ~32'hF) | guard);
		cfg_ch.valid = 1'b0;
		cur_base = base;
		cur_lg = lg;
		cur_n = n;
		cur_guard = guard;
	endtask

	task automatic random_item();
		int roll;
		roll = $urandom_range(99);
		if (roll < 45)
			send(CMD_ALLOC, $urandom());
		else if (roll < 80)
			send(CMD_FREE, random_free_address());
		else if (roll < 95)
			send(CMD_QUERY, $urandom());
		else
			send(CMD_UNUSED, $urandom());
	endtask

	initial begin
		int                 p;
		int                 roll;
		logic [ADDR_W-1:0]  nb;
		logic [BSL_W-1:0]   nl;
		logic [BIU_W-1:0]   nn;
		logic [GUARD_W-1:0] ng;
		arst_n = 1'b0;
		steady = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_ALLOC;
		req_ch.block_address = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_HEAP_BASE;
		cfg_ch.data = '0;
		rsp_ch.ready = 1'b0;
		cur_base = '0;
		cur_lg = 4'd4;
		cur_n = 9'd256;
		cur_guard = 4'd8;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		send(CMD_ALLOC, 32'h0000_0000);
		send(CMD_ALLOC, 32'hFFFF_FFFF);
		send(CMD_ALLOC, $urandom());
		send(CMD_QUERY, $urandom());
		send(CMD_FREE, payload_start(1));
		send(CMD_FREE, payload_start(1));
		send(CMD_FREE, payload_start(1) + 1);
		send(CMD_FREE, payload_start(NUM_BLOCKS));
		send(CMD_FREE, 32'h0000_0000);
		send(CMD_FREE, 32'hFFFF_FFFF);
		send(CMD_UNUSED, 32'hFFFF_FFFF);
		send(CMD_ALLOC, 32'h0000_0000);

		apply_setting(32'h0000_0000, 4'd4, 9'd0, 4'd8);
		send(CMD_ALLOC, $urandom());
		send(CMD_FREE, payload_start(0));
		send(CMD_QUERY, $urandom());

		apply_setting(32'h0000_0000, 4'd4, 9'd2, 4'd8);
		send(CMD_ALLOC, $urandom());
		send(CMD_QUERY, $urandom());
		send(CMD_FREE, payload_start(2));
		send(CMD_FREE, payload_start(0));

		apply_setting(32'hFFFF_FFF0, 4'd15, 9'd511, 4'd15);
		send(CMD_ALLOC, $urandom());
		send(CMD_ALLOC, $urandom());
		send(CMD_FREE, payload_start(3));
		send(CMD_QUERY, $urandom());

		apply_setting(32'h0000_0000, 4'd0, 9'd1, 4'd0);
		send(CMD_FREE, payload_start(0));
		send(CMD_ALLOC, $urandom());
		send(CMD_ALLOC, $urandom());
		send(CMD_FREE, payload_start(1));

		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin
					nb = 32'h0000_0000; nl = 4'd12; nn = 9'd256; ng = 4'd0;
				end
				1: begin
					nb = 32'hFFFF_FFFF; nl = 4'd0; nn = 9'd1; ng = 4'd8;
				end
				2: begin
					nb = $urandom(); nl = BSL_W'(13 + $urandom_range(2));
					nn = BIU_W'(300 + $urandom_range(211)); ng = 4'd12;
				end
				3: begin
					nb = $urandom(); nl = BSL_W'($urandom_range(LG_MAX)); nn = 9'd0;
					ng = GUARD_W'($urandom_range(GUARD_MAX));
				end
				default: begin
					nb = $urandom();
					nl = ($urandom_range(99) < 10) ? BSL_W'(13 + $urandom_range(2))
						: BSL_W'($urandom_range(LG_MAX));
					roll = $urandom_range(99);
					if (roll < 50)
						nn = BIU_W'($urandom_range(40, 1));
					else if (roll < 70)
						nn = BIU_W'($urandom_range(256, 41));
					else if (roll < 85)
						nn = 9'd256;
					else if (roll < 95)
						nn = BIU_W'($urandom_range(511, 257));
					else
						nn = 9'd0;
					ng = ($urandom_range(99) < 15) ? GUARD_W'(9 + $urandom_range(6))
						: GUARD_W'($urandom_range(GUARD_MAX));
				end
			endcase
			apply_setting(nb, nl, nn, ng);
			steady = (p == 7 || p == 8);
			repeat (ITEMS_PER_PHASE) random_item();
		end

		settle();
		steady = 1'b0;
		repeat (8) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("PASS bitmap_block_allocator");
		end else begin
			$display("FAIL bitmap_block_allocator");
		end
		$finish;
	end

endmodule
`default_nettype wire
